// ===== design/ttbd_pkg.sv =====
// Shared types, format codes and color expansion helpers for the tiled texture decoder.
// Depends on nothing; every other design file but ttbd_if.sv imports it.
`timescale 1ns / 1ps

package ttbd_pkg;

   // Texture format codes.
   localparam logic [3:0] FMT_I4     = 4'd0;
   localparam logic [3:0] FMT_I8     = 4'd1;
   localparam logic [3:0] FMT_IA4    = 4'd2;
   localparam logic [3:0] FMT_IA8    = 4'd3;
   localparam logic [3:0] FMT_RGB565 = 4'd4;
   localparam logic [3:0] FMT_RGB5A3 = 4'd5;
   localparam logic [3:0] FMT_RGBA8  = 4'd6;
   localparam logic [3:0] FMT_C4     = 4'd7;
   localparam logic [3:0] FMT_C8     = 4'd8;
   localparam logic [3:0] FMT_C14X2  = 4'd9;
   localparam logic [3:0] FMT_CMPR   = 4'd10;

   // Palette entry encodings.
   localparam logic [1:0] PAL_IA8    = 2'd0;
   localparam logic [1:0] PAL_RGB565 = 2'd1;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_TEX_FMT = 2'd0;
   localparam logic [1:0] REG_PAL_FMT = 2'd1;
   localparam logic [1:0] REG_WIDTH   = 2'd2;
   localparam logic [1:0] REG_HEIGHT  = 2'd3;

   // Input operations.
   localparam logic OP_PAL_WRITE = 1'b0;
   localparam logic OP_DATA_WORD = 1'b1;

   localparam int PAL_ENTRIES = 16384;
   localparam int PAL_AW      = $clog2(PAL_ENTRIES);
   localparam int MAX_DIM     = 1024;
   localparam int DIM_W       = 11;
   localparam int TILE_WORDS  = 8;
   localparam int TILE_AW     = 3;

   // Words of one tile and the palette entries they index.
   typedef logic [63:0]        word_type;
   typedef logic [15:0]        pal_entry_type;
   typedef logic [PAL_AW-1:0]  pal_addr_type;
   typedef logic [TILE_AW-1:0] tile_addr_type;

   function automatic logic [7:0] ex3(input logic [2:0] v);
      return {v, v, v[2:1]};
   endfunction

   function automatic logic [7:0] ex4(input logic [3:0] v);
      return {v, v};
   endfunction

   function automatic logic [7:0] ex5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] ex6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   function automatic logic [31:0] rgb565(input logic [15:0] v);
      return {ex5(v[15:11]), ex6(v[10:5]), ex5(v[4:0]), 8'hFF};
   endfunction

   function automatic logic [31:0] rgb5a3(input logic [15:0] v);
      logic [31:0] c;
      if (v[15]) begin
         c = {ex5(v[14:10]), ex5(v[9:5]), ex5(v[4:0]), 8'hFF};
      end else begin
         c = {ex4(v[11:8]), ex4(v[7:4]), ex4(v[3:0]), ex3(v[14:12])};
      end
      return c;
   endfunction

   // Decode a palette entry; the two codes without a name, 2 and 3, both decode as RGB5A3.
   function automatic logic [31:0] pal_color(input logic [1:0] pf, input logic [15:0] v);
      logic [31:0] c;
      if (pf == PAL_IA8) begin
         c = {v[7:0], v[7:0], v[7:0], v[15:8]};
      end else if (pf == PAL_RGB565) begin
         c = rgb565(v);
      end else begin
         c = rgb5a3(v);
      end
      return c;
   endfunction

   // Blend three parts of a with five parts of b.
   function automatic logic [7:0] mix38(input logic [7:0] a, input logic [7:0] b);
      logic [10:0] s;
      s = ({3'b0, a} << 1) + {3'b0, a} + ({3'b0, b} << 2) + {3'b0, b};
      return s[10:3];
   endfunction

   function automatic logic [7:0] avg2(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8:1];
   endfunction

   function automatic logic [7:0] get_byte(input word_type w, input logic [2:0] k);
      return 8'(w >> {~k, 3'b000});
   endfunction

   function automatic logic [15:0] get_half(input word_type w, input logic [1:0] k);
      return 16'(w >> {~k, 4'b0000});
   endfunction

   // Control carried with a texel from the address stage to the decode stage.
   typedef struct packed {
      logic       valid;
      logic       tile_last;
      logic       image_last;
      logic [9:0] x;
      logic [9:0] y;
      logic [5:0] idx;
   } s1_type;

   // Texel after decode, waiting for its palette entry where one is needed.
   typedef struct packed {
      logic        valid;
      logic        tile_last;
      logic        image_last;
      logic [9:0]  x;
      logic [9:0]  y;
      logic        use_pal;
      logic [31:0] color;
   } s2_type;

endpackage

// ===== design/ttbd_if.sv =====
// Channel interfaces of the tiled texture decoder: input words, texels, register writes.
// Depends on nothing.
`timescale 1ns / 1ps

interface ttbd_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [63:0] data_word;
   logic [13:0] palette_index;
   modport source (output valid, operation, data_word, palette_index, input ready);
   modport sink (input valid, operation, data_word, palette_index, output ready);
endinterface

interface ttbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  texel_x;
   logic [9:0]  texel_y;
   logic [31:0] texel_color;
   logic        tile_last;
   logic        image_last;
   modport source (output valid, texel_x, texel_y, texel_color, tile_last, image_last,
                   input ready);
   modport sink (input valid, texel_x, texel_y, texel_color, tile_last, image_last,
                 output ready);
endinterface

interface ttbd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [10:0] write_data;
   modport source (output valid, index, write_data, input ready);
   modport sink (input valid, index, write_data, output ready);
endinterface

// ===== design/tiled_texture_block_decoder.sv =====
// Top level of the tiled texture decoder: word collection, texel walk, decode pipeline.
// Depends on ttbd_pkg, ttbd_if, ttbd_tile_mem and ttbd_pal_mem.
`timescale 1ns / 1ps

// Data words are gathered into a tile buffer; once a tile is complete the block walks its
// 16, 32 or 64 texels one per cycle, unless the output stalls, through a three-stage
// pipeline (tile buffer read, decode and palette read, color finish) and emits every texel
// inside the image. Input is held off during the walk and, when the last texel of the walk
// lies inside the image, until that texel leaves the address stage register. Texels
// outside the image are walked as well but not emitted. Any register write restarts the
// image.

module tiled_texture_block_decoder
   import ttbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ttbd_req_if.sink   req_ch,
   ttbd_rsp_if.source rsp_ch,
   ttbd_csr_if.sink   csr_ch
);

   // Configuration registers.
   logic [3:0]       tex_fmt_ff, tex_fmt_in;
   logic [1:0]       pal_fmt_ff, pal_fmt_in;
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;

   // Walk state.
   logic [2:0]       words_ff, words_in;
   logic [DIM_W-1:0] bx_ff, bx_in;
   logic [DIM_W-1:0] by_ff, by_in;
   logic             running_ff, running_in;
   logic [5:0]       idx_ff, idx_in;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [9:0]  rsp_x_ff, rsp_y_ff;
   logic [31:0] rsp_color_ff, rsp_color_in;
   logic        rsp_tile_last_ff, rsp_image_last_ff;

   logic req_xfer, csr_xfer, adv;
   logic fmt_ok, is_cmpr, wide8, tall8;
   logic [3:0] tw, th, tile_words;
   logic [5:0] idx_last;
   logic [DIM_W-1:0] w_eff, h_eff;
   logic tile_done, last_tile;

   word_type      tile_a, tile_b;
   tile_addr_type rd_addr_a, rd_addr_b;
   pal_entry_type pal_data;
   pal_addr_type  pal_rd_addr;

   assign csr_ch.ready = 1'b1;
   assign csr_xfer     = csr_ch.valid && csr_ch.ready;
   assign req_ch.ready = !running_ff && !s1_ff.valid;
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign adv          = !rsp_valid_ff || rsp_ch.ready;

   // Tile geometry of the current format.
   always_comb begin
      fmt_ok  = (tex_fmt_ff <= FMT_CMPR);
      is_cmpr = (tex_fmt_ff == FMT_CMPR);
      tall8   = (tex_fmt_ff == FMT_I4) || (tex_fmt_ff == FMT_C4) || is_cmpr;
      wide8   = tall8 || (tex_fmt_ff == FMT_I8) || (tex_fmt_ff == FMT_IA4)
                || (tex_fmt_ff == FMT_C8);
      tw      = wide8 ? 4'd8 : 4'd4;
      th      = tall8 ? 4'd8 : 4'd4;
      tile_words = (tex_fmt_ff == FMT_RGBA8) ? 4'd8 : 4'd4;
      idx_last   = tall8 ? 6'd63 : (wide8 ? 6'd31 : 6'd15);
   end

   // Image size with zero taken as one and oversize taken as the maximum.
   always_comb begin
      w_eff = width_ff;
      h_eff = height_ff;
      if (width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (width_ff > DIM_W'(MAX_DIM)) begin
         w_eff = DIM_W'(MAX_DIM);
      end
      if (height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (height_ff > DIM_W'(MAX_DIM)) begin
         h_eff = DIM_W'(MAX_DIM);
      end
      last_tile = (bx_ff + DIM_W'(tw) >= w_eff) && (by_ff + DIM_W'(th) >= h_eff);
   end

   // Configuration writes; each one restarts the image.
   always_comb begin
      tex_fmt_in = tex_fmt_ff;
      pal_fmt_in = pal_fmt_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      if (csr_xfer) begin
         unique case (csr_ch.index)
            REG_TEX_FMT: tex_fmt_in = csr_ch.write_data[3:0];
            REG_PAL_FMT: pal_fmt_in = csr_ch.write_data[1:0];
            REG_WIDTH:   width_in   = csr_ch.write_data;
            REG_HEIGHT:  height_in  = csr_ch.write_data;
         endcase
      end
   end

   // Word collection, texel walk counter and tile position.
   always_comb begin
      words_in   = words_ff;
      bx_in      = bx_ff;
      by_in      = by_ff;
      running_in = running_ff;
      idx_in     = idx_ff;
      tile_done  = 1'b0;
      if (req_xfer && req_ch.operation == OP_DATA_WORD && fmt_ok) begin
         if ({1'b0, words_ff} + 4'd1 == tile_words) begin
            words_in   = '0;
            tile_done  = 1'b1;
            running_in = 1'b1;
            idx_in     = '0;
         end else begin
            words_in = words_ff + 3'd1;
         end
      end
      if (running_ff && adv) begin
         idx_in = idx_ff + 6'd1;
         if (idx_ff == idx_last) begin
            running_in = 1'b0;
            if (bx_ff + DIM_W'(tw) < w_eff) begin
               bx_in = bx_ff + DIM_W'(tw);
            end else begin
               bx_in = '0;
               by_in = (by_ff + DIM_W'(th) < h_eff) ? by_ff + DIM_W'(th) : '0;
            end
         end
      end
      if (csr_xfer) begin
         words_in = '0;
         bx_in    = '0;
         by_in    = '0;
      end
   end

   // Address stage: texel position, clipping and tile buffer addresses.
   always_comb begin
      logic [2:0] lx, ly;
      logic [DIM_W-1:0] tx, ty;
      logic last_x, last_y;
      if (is_cmpr) begin
         lx = {idx_ff[4], idx_ff[1:0]};
         ly = {idx_ff[5], idx_ff[3:2]};
      end else if (wide8) begin
         lx = idx_ff[2:0];
         ly = idx_ff[5:3];
      end else begin
         lx = {1'b0, idx_ff[1:0]};
         ly = {1'b0, idx_ff[3:2]};
      end
      tx     = bx_ff + DIM_W'(lx);
      ty     = by_ff + DIM_W'(ly);
      last_x = ({1'b0, lx} == tw - 4'd1) || (tx + DIM_W'(1) == w_eff);
      last_y = ({1'b0, ly} == th - 4'd1) || (ty + DIM_W'(1) == h_eff);
      s1_in.valid      = running_ff && (tx < w_eff) && (ty < h_eff);
      s1_in.tile_last  = last_x && last_y;
      s1_in.image_last = last_x && last_y && last_tile;
      s1_in.x          = tx[9:0];
      s1_in.y          = ty[9:0];
      s1_in.idx        = idx_ff;
      if (tall8) begin
         rd_addr_a = {1'b0, idx_ff[5:4]};
      end else if (wide8) begin
         rd_addr_a = {1'b0, idx_ff[4:3]};
      end else begin
         rd_addr_a = {1'b0, idx_ff[3:2]};
      end
      rd_addr_b = {1'b1, idx_ff[3:2]};
   end

   // Decode stage: direct colors, CMPR blends and the palette index.
   always_comb begin
      logic [5:0]  i;
      logic [7:0]  bt, sb;
      logic [3:0]  nib;
      logic [15:0] ha, hb, e0, e1;
      logic [31:0] c0, c1;
      logic [1:0]  sel;
      i   = s1_ff.idx;
      bt  = get_byte(tile_a, wide8 && !tall8 ? i[2:0] : i[3:1]);
      nib = i[0] ? bt[3:0] : bt[7:4];
      ha  = get_half(tile_a, i[1:0]);
      hb  = get_half(tile_b, i[1:0]);
      e0  = tile_a[63:48];
      e1  = tile_a[47:32];
      c0  = rgb565(e0);
      c1  = rgb565(e1);
      sb  = get_byte(tile_a, {1'b1, i[3:2]});
      sel = 2'(sb >> {~i[1:0], 1'b0});
      s2_in.valid      = s1_ff.valid;
      s2_in.tile_last  = s1_ff.tile_last;
      s2_in.image_last = s1_ff.image_last;
      s2_in.x          = s1_ff.x;
      s2_in.y          = s1_ff.y;
      s2_in.use_pal    = 1'b0;
      s2_in.color      = '0;
      pal_rd_addr      = '0;
      unique case (tex_fmt_ff)
         FMT_I4:     s2_in.color = {4{ex4(nib)}};
         FMT_I8:     s2_in.color = {4{bt}};
         FMT_IA4:    s2_in.color = {ex4(bt[3:0]), ex4(bt[3:0]), ex4(bt[3:0]), ex4(bt[7:4])};
         FMT_IA8:    s2_in.color = {ha[7:0], ha[7:0], ha[7:0], ha[15:8]};
         FMT_RGB565: s2_in.color = rgb565(ha);
         FMT_RGB5A3: s2_in.color = rgb5a3(ha);
         FMT_RGBA8:  s2_in.color = {ha[7:0], hb[15:8], hb[7:0], ha[15:8]};
         FMT_C4: begin
            s2_in.use_pal = 1'b1;
            pal_rd_addr   = PAL_AW'(nib);
         end
         FMT_C8: begin
            s2_in.use_pal = 1'b1;
            pal_rd_addr   = PAL_AW'(bt);
         end
         FMT_C14X2: begin
            s2_in.use_pal = 1'b1;
            pal_rd_addr   = ha[13:0];
         end
         FMT_CMPR: begin
            if (sel == 2'd0) begin
               s2_in.color = c0;
            end else if (sel == 2'd1) begin
               s2_in.color = c1;
            end else if (e0 > e1) begin
               if (sel == 2'd2) begin
                  s2_in.color = {mix38(c1[31:24], c0[31:24]), mix38(c1[23:16], c0[23:16]),
                                 mix38(c1[15:8], c0[15:8]), 8'hFF};
               end else begin
                  s2_in.color = {mix38(c0[31:24], c1[31:24]), mix38(c0[23:16], c1[23:16]),
                                 mix38(c0[15:8], c1[15:8]), 8'hFF};
               end
            end else begin
               s2_in.color = {avg2(c0[31:24], c1[31:24]), avg2(c0[23:16], c1[23:16]),
                              avg2(c0[15:8], c1[15:8]), (sel == 2'd2) ? 8'hFF : 8'h00};
            end
         end
         default: s2_in.color = '0;
      endcase
   end

   // Finish stage: palette decode where needed.
   assign rsp_color_in = s2_ff.use_pal ? pal_color(pal_fmt_ff, pal_data) : s2_ff.color;
   assign rsp_valid_in = s2_ff.valid;

   // Control and pipeline registers; the pipeline stages reset only their valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         tex_fmt_ff   <= FMT_I4;
         pal_fmt_ff   <= PAL_IA8;
         width_ff     <= DIM_W'(1);
         height_ff    <= DIM_W'(1);
         words_ff     <= '0;
         bx_ff        <= '0;
         by_ff        <= '0;
         running_ff   <= 1'b0;
         idx_ff       <= '0;
         s1_ff.valid  <= 1'b0;
         s2_ff.valid  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tex_fmt_ff <= tex_fmt_in;
         pal_fmt_ff <= pal_fmt_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         words_ff   <= words_in;
         bx_ff      <= bx_in;
         by_ff      <= by_in;
         running_ff <= running_in;
         idx_ff     <= idx_in;
         if (adv) begin
            s1_ff             <= s1_in;
            s2_ff             <= s2_in;
            rsp_valid_ff      <= rsp_valid_in;
            rsp_x_ff          <= s2_ff.x;
            rsp_y_ff          <= s2_ff.y;
            rsp_color_ff      <= rsp_color_in;
            rsp_tile_last_ff  <= s2_ff.tile_last;
            rsp_image_last_ff <= s2_ff.image_last;
         end
      end
   end

   ttbd_tile_mem u_tile_mem (
      .clock     (clock),
      .wr_en     (req_xfer && req_ch.operation == OP_DATA_WORD && fmt_ok),
      .wr_addr   (words_ff),
      .wr_data   (req_ch.data_word),
      .rd_en     (adv && running_ff),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (tile_a),
      .rd_data_b (tile_b)
   );

   ttbd_pal_mem u_pal_mem (
      .clock   (clock),
      .wr_en   (req_xfer && req_ch.operation == OP_PAL_WRITE),
      .wr_addr (req_ch.palette_index),
      .wr_data (req_ch.data_word[15:0]),
      .rd_en   (adv),
      .rd_addr (pal_rd_addr),
      .rd_data (pal_data)
   );

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.texel_x     = rsp_x_ff;
   assign rsp_ch.texel_y     = rsp_y_ff;
   assign rsp_ch.texel_color = rsp_color_ff;
   assign rsp_ch.tile_last   = rsp_tile_last_ff;
   assign rsp_ch.image_last  = rsp_image_last_ff;

   // The last texel of the image always closes its tile.
   a_image_in_tile: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_image_last_ff |-> rsp_tile_last_ff)
      else $error("image_last without tile_last");

   // An empty pipeline does not produce a texel in the next cycle.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      !running_ff && !s1_ff.valid && !s2_ff.valid && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("texel appeared from an empty pipeline");

   // Only RGBA8 tiles collect more than four words.
   a_word_count: assert property (@(posedge clock) disable iff (reset)
      tex_fmt_ff != FMT_RGBA8 |-> !words_ff[2])
      else $error("word count beyond a four-word tile");

   // A texel walk starts only from a completed tile.
   a_walk_start: assert property (@(posedge clock) disable iff (reset)
      $rose(running_ff) |-> $past(tile_done))
      else $error("texel walk started without a complete tile");

endmodule

// ===== design/ttbd_tile_mem.sv =====
// Tile buffer: eight 64-bit words, one write port and two registered read ports.
// Depends on ttbd_pkg.
`timescale 1ns / 1ps

module ttbd_tile_mem
   import ttbd_pkg::*;
(
   input  logic          clock,
   input  logic          wr_en,
   input  tile_addr_type wr_addr,
   input  word_type      wr_data,
   input  logic          rd_en,
   input  tile_addr_type rd_addr_a,
   input  tile_addr_type rd_addr_b,
   output word_type      rd_data_a,
   output word_type      rd_data_b
);

   word_type mem [TILE_WORDS];
   word_type rd_a_ff;
   word_type rd_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read ports; data holds while the pipeline is stalled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== design/ttbd_pal_mem.sv =====
// Palette store: 16-bit entries, one write port and one registered read port.
// Depends on ttbd_pkg.
`timescale 1ns / 1ps

module ttbd_pal_mem
   import ttbd_pkg::*;
(
   input  logic          clock,
   input  logic          wr_en,
   input  pal_addr_type  wr_addr,
   input  pal_entry_type wr_data,
   input  logic          rd_en,
   input  pal_addr_type  rd_addr,
   output pal_entry_type rd_data
);

   pal_entry_type mem [PAL_ENTRIES];
   pal_entry_type rd_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; a read of the entry being written returns the old contents.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the tiled texture block decoder: every format, palette path,
// clipping and image walk, checked texel by texel. Depends on ttbd_pkg, ttbd_if and the RTL.
`timescale 1ns / 1ps

module tb_top
   import ttbd_pkg::*;
();

   typedef struct {
      logic        op;
      logic [63:0] data;
      logic [13:0] pidx;
   } word_item_type;

   typedef struct {
      logic [9:0]  x;
      logic [9:0]  y;
      logic [31:0] color;
      logic        tile_last;
      logic        image_last;
   } texel_type;

   logic clock;
   logic reset;

   ttbd_req_if req_bus ();
   ttbd_rsp_if rsp_bus ();
   ttbd_csr_if csr_bus ();

   tiled_texture_block_decoder u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   word_item_type pending_words[$];
   texel_type     expected_texels[$];
   int          error_count;
   int          words_accepted;
   int          texels_checked;
   int          cycle_count;
   int          send_idle;
   int          recv_idle;
   int          hold_cycles;
   bit          hold_done;

   // Shadow state of the decoder.
   logic [63:0] tile_buf[8];
   int          words_in_tile;
   int          tile_col;
   int          tile_row;
   logic [15:0] palette_mem[PAL_ENTRIES];
   bit          palette_written[PAL_ENTRIES];
   int          written_list[$];
   logic [3:0]  tex_fmt;
   logic [1:0]  pal_fmt;
   int          img_w;
   int          img_h;

   // Clock and the single reset at the start.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic logic [7:0] x3(logic [2:0] v);
      return {v, v, v[2:1]};
   endfunction
   function automatic logic [7:0] x4(logic [3:0] v);
      return {v, v};
   endfunction
   function automatic logic [7:0] x5(logic [4:0] v);
      return {v, v[4:2]};
   endfunction
   function automatic logic [7:0] x6(logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   function automatic logic [7:0] tile_byte(int b);
      b = b & 63;
      return tile_buf[b >> 3][63 - 8 * (b & 7) -: 8];
   endfunction

   function automatic logic [15:0] tile_half(int b);
      return {tile_byte(b), tile_byte(b + 1)};
   endfunction

   function automatic logic [31:0] from_565(logic [15:0] v);
      return {x5(v[15:11]), x6(v[10:5]), x5(v[4:0]), 8'hFF};
   endfunction

   function automatic logic [31:0] from_5a3(logic [15:0] v);
      if (v[15]) return {x5(v[14:10]), x5(v[9:5]), x5(v[4:0]), 8'hFF};
      return {x4(v[11:8]), x4(v[7:4]), x4(v[3:0]), x3(v[14:12])};
   endfunction

   function automatic logic [31:0] palette_lookup(int idx);
      logic [15:0] v;
      v = (idx < PAL_ENTRIES) ? palette_mem[idx] : 16'h0000;
      if (pal_fmt == PAL_IA8) return {v[7:0], v[7:0], v[7:0], v[15:8]};
      if (pal_fmt == PAL_RGB565) return from_565(v);
      return from_5a3(v);
   endfunction

   function automatic logic [7:0] blend38(logic [7:0] a, logic [7:0] b);
      int s;
      s = (a * 3 + b * 5) >> 3;
      return s[7:0];
   endfunction

   // One texel of a compressed 4x4 sub-block starting at byte base.
   function automatic logic [31:0] cmpr_color(int base, int p);
      logic [15:0] e0, e1;
      logic [31:0] c0, c1;
      logic [1:0]  sel;
      logic [7:0]  sb;
      int          r, g, b;
      e0  = tile_half(base);
      e1  = tile_half(base + 2);
      c0  = from_565(e0);
      c1  = from_565(e1);
      sb  = tile_byte(base + 4 + (p >> 2));
      sel = sb[7 - 2 * (p & 3) -: 2];
      if (sel == 2'd0) return c0;
      if (sel == 2'd1) return c1;
      if (e0 > e1) begin
         if (sel == 2'd2)
            return {blend38(c1[31:24], c0[31:24]), blend38(c1[23:16], c0[23:16]),
                    blend38(c1[15:8], c0[15:8]), 8'hFF};
         return {blend38(c0[31:24], c1[31:24]), blend38(c0[23:16], c1[23:16]),
                 blend38(c0[15:8], c1[15:8]), 8'hFF};
      end
      r = (c0[31:24] + c1[31:24]) / 2;
      g = (c0[23:16] + c1[23:16]) / 2;
      b = (c0[15:8] + c1[15:8]) / 2;
      return {r[7:0], g[7:0], b[7:0], (sel == 2'd2) ? 8'hFF : 8'h00};
   endfunction

   function automatic logic [31:0] plain_color(int p);
      logic [7:0] v;
      case (tex_fmt)
         FMT_I4: begin
            v = tile_byte(p >> 1);
            v = x4((p & 1) ? v[3:0] : v[7:4]);
            return {v, v, v, v};
         end
         FMT_I8: begin
            v = tile_byte(p);
            return {v, v, v, v};
         end
         FMT_IA4: begin
            v = tile_byte(p);
            return {x4(v[3:0]), x4(v[3:0]), x4(v[3:0]), x4(v[7:4])};
         end
         FMT_IA8: begin
            v = tile_byte(p * 2 + 1);
            return {v, v, v, tile_byte(p * 2)};
         end
         FMT_RGB565: return from_565(tile_half(p * 2));
         FMT_RGB5A3: return from_5a3(tile_half(p * 2));
         FMT_RGBA8:
            return {tile_byte(p * 2 + 1), tile_byte(32 + p * 2), tile_byte(33 + p * 2),
                    tile_byte(p * 2)};
         FMT_C4: begin
            v = tile_byte(p >> 1);
            return palette_lookup((p & 1) ? v[3:0] : v[7:4]);
         end
         FMT_C8: return palette_lookup(tile_byte(p));
         default: return palette_lookup(tile_half(p * 2) & 16'h3FFF);
      endcase
   endfunction

   function automatic int clamp_size(int v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   // Updates the shadow state for one accepted input item and queues its texels.
   task automatic predict_texels(logic op, logic [63:0] data, logic [13:0] pidx);
      int        tw, th, nwords, w, h, tx, ty, bx, by, lx, ly, s, p, i;
      int        first_new;
      bit        last_tile;
      texel_type t;
      if (op == OP_PAL_WRITE) begin
         palette_mem[pidx] = data[15:0];
         return;
      end
      nwords = 4;
      case (tex_fmt)
         FMT_I4, FMT_C4, FMT_CMPR: begin tw = 8; th = 8; end
         FMT_I8, FMT_IA4, FMT_C8:  begin tw = 8; th = 4; end
         FMT_IA8, FMT_RGB565, FMT_RGB5A3, FMT_C14X2: begin tw = 4; th = 4; end
         FMT_RGBA8: begin tw = 4; th = 4; nwords = 8; end
         default: return;
      endcase
      tile_buf[words_in_tile & 7] = data;
      words_in_tile = (words_in_tile + 1) & 7;
      if (words_in_tile != 0 && words_in_tile < nwords) return;
      words_in_tile = 0;
      w  = clamp_size(img_w);
      h  = clamp_size(img_h);
      tx = (w + tw - 1) / tw;
      ty = (h + th - 1) / th;
      if (tile_col >= tx || tile_row >= ty) begin
         tile_col = 0;
         tile_row = 0;
      end
      bx = tile_col * tw;
      by = tile_row * th;
      last_tile = (tile_col + 1 == tx) && (tile_row + 1 == ty);
      first_new = expected_texels.size();
      for (i = 0; i < tw * th; i++) begin
         if (tex_fmt == FMT_CMPR) begin
            s  = i >> 4;
            p  = i & 15;
            lx = (s & 1) * 4 + (p & 3);
            ly = (s >> 1) * 4 + (p >> 2);
         end else begin
            lx = i % tw;
            ly = i / tw;
         end
         if (bx + lx < w && by + ly < h) begin
            t.x          = 10'(bx + lx);
            t.y          = 10'(by + ly);
            t.color      = (tex_fmt == FMT_CMPR) ? cmpr_color(s * 8, p) : plain_color(i);
            t.tile_last  = 1'b0;
            t.image_last = 1'b0;
            expected_texels.push_back(t);
         end
      end
      if (expected_texels.size() > first_new) begin
         expected_texels[$].tile_last  = 1'b1;
         expected_texels[$].image_last = last_tile;
      end
      if (tile_col + 1 < tx) begin
         tile_col++;
      end else begin
         tile_col = 0;
         tile_row = (tile_row + 1 < ty) ? tile_row + 1 : 0;
      end
   endtask

   // Input driver: offers the oldest pending item and predicts it on transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid         <= 1'b0;
         req_bus.operation     <= OP_DATA_WORD;
         req_bus.data_word     <= '0;
         req_bus.palette_index <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_texels(req_bus.operation, req_bus.data_word, req_bus.palette_index);
            void'(pending_words.pop_front());
            words_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
               req_bus.valid         <= 1'b1;
               req_bus.operation     <= pending_words[0].op;
               req_bus.data_word     <= pending_words[0].data;
               req_bus.palette_index <= pending_words[0].pidx;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Idle mix by progress: receiver idles more first, then the sender, then neither.
   always @(posedge clock) begin
      if (words_accepted < 300) begin
         send_idle <= 22;
         recv_idle <= 45;
      end else if (words_accepted < 390) begin
         send_idle <= 45;
         recv_idle <= 22;
      end else begin
         send_idle <= 0;
         recv_idle <= 0;
      end
   end

   // Receiver ready, with one long hold-off so the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_cycles   <= 0;
         hold_done     <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles   <= hold_cycles - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && words_accepted >= 340) begin
         hold_done     <= 1'b1;
         hold_cycles   <= 400;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // Output monitor: each texel transfer is checked against the oldest expectation.
   always @(posedge clock) begin
      texel_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_texels.size() == 0) begin
            $error("unexpected texel at x=%0d y=%0d", rsp_bus.texel_x, rsp_bus.texel_y);
            error_count++;
         end else begin
            e = expected_texels.pop_front();
            texels_checked++;
            if (rsp_bus.texel_x !== e.x) begin
               $error("texel_x expected %0d actual %0d", e.x, rsp_bus.texel_x);
               error_count++;
            end
            if (rsp_bus.texel_y !== e.y) begin
               $error("texel_y expected %0d actual %0d", e.y, rsp_bus.texel_y);
               error_count++;
            end
            if (rsp_bus.texel_color !== e.color) begin
               $error("texel_color expected %h actual %h", e.color, rsp_bus.texel_color);
               error_count++;
            end
            if (rsp_bus.tile_last !== e.tile_last) begin
               $error("tile_last expected %0d actual %0d", e.tile_last, rsp_bus.tile_last);
               error_count++;
            end
            if (rsp_bus.image_last !== e.image_last) begin
               $error("image_last expected %0d actual %0d", e.image_last,
                      rsp_bus.image_last);
               error_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 1500000) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // One register write; the shadow image walk restarts on the transfer.
   task automatic write_register(logic [1:0] idx, logic [10:0] value);
      csr_bus.valid      <= 1'b1;
      csr_bus.index      <= idx;
      csr_bus.write_data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         REG_TEX_FMT: tex_fmt = value[3:0];
         REG_PAL_FMT: pal_fmt = value[1:0];
         REG_WIDTH:   img_w = value;
         default:     img_h = value;
      endcase
      words_in_tile = 0;
      tile_col      = 0;
      tile_row      = 0;
   endtask

   task automatic configure(logic [10:0] fmt, logic [10:0] pf, logic [10:0] w,
                            logic [10:0] h);
      write_register(REG_TEX_FMT, fmt);
      write_register(REG_PAL_FMT, pf);
      write_register(REG_WIDTH, w);
      write_register(REG_HEIGHT, h);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every item is in and every texel out, then lets the pipeline settle.
   task automatic drain();
      while (pending_words.size() > 0 || req_bus.valid || expected_texels.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic push_word(logic op, logic [63:0] data, logic [13:0] pidx);
      word_item_type it;
      it.op   = op;
      it.data = data;
      it.pidx = pidx;
      if (op == OP_PAL_WRITE && !palette_written[pidx]) begin
         palette_written[pidx] = 1'b1;
         written_list.push_back(pidx);
      end
      pending_words.push_back(it);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Random data word for the current format; wide palette indexes hit written entries.
   function automatic logic [63:0] data_for(logic [3:0] fmt);
      logic [63:0] d;
      logic [13:0] pi;
      d = rand64();
      if (fmt == FMT_C14X2) begin
         for (int k = 0; k < 4; k++) begin
            pi = written_list[$urandom_range(written_list.size() - 1)];
            d[63 - 16 * k -: 16] = {d[63 - 16 * k -: 2], pi};
         end
      end
      return d;
   endfunction

   function automatic logic [10:0] rand_size();
      case ($urandom_range(9))
         0: return 11'd0;
         1: return 11'd1024;
         2: return 11'($urandom_range(2047, 1025));
         default: return 11'($urandom_range(40, 1));
      endcase
   endfunction

   // Stimulus.
   initial begin
      logic [3:0] fmt;
      int         nwords, count;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = REG_TEX_FMT;
      csr_bus.write_data = '0;
      error_count    = 0;
      words_accepted = 0;
      texels_checked = 0;
      cycle_count    = 0;
      send_idle      = 22;
      recv_idle      = 45;
      words_in_tile  = 0;
      tile_col       = 0;
      tile_row       = 0;
      tex_fmt        = FMT_I4;
      pal_fmt        = PAL_IA8;
      img_w          = 1;
      img_h          = 1;
      for (int k = 0; k < PAL_ENTRIES; k++) begin
         palette_mem[k]     = 16'h0000;
         palette_written[k] = 1'b0;
      end
      @(negedge reset);
      @(posedge clock);

      // Load the low 256 palette entries plus scattered ones, the top entry among them.
      for (int k = 0; k < 256; k++) push_word(OP_PAL_WRITE, rand64(), 14'(k));
      push_word(OP_PAL_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 14'h3FFF);
      for (int k = 0; k < 20; k++) push_word(OP_PAL_WRITE, rand64(), 14'($urandom));
      drain();

      // Directed: one tile per format with extreme bytes, both compressed color orders.
      for (int f = 0; f <= 10; f++) begin
         configure(11'(f), 11'(f % 4), 11'd8, 11'd8);
         nwords = (f == FMT_RGBA8) ? 8 : 4;
         for (int k = 0; k < nwords; k++) begin
            if (f == FMT_CMPR)
               push_word(OP_DATA_WORD, (k % 2) ? 64'h0000_FFFF_1B1B_E4E4
                                                : 64'hFFFF_0000_E4E4_1B1B, '0);
            else
               push_word(OP_DATA_WORD, (k % 2) ? 64'h0 : 64'hFFFF_FFFF_FFFF_FFFF, '0);
         end
         drain();
      end
      // An unused format code ignores its data words.
      configure(11'd12, 11'd3, 11'd5, 11'd3);
      push_word(OP_DATA_WORD, rand64(), '0);
      push_word(OP_DATA_WORD, rand64(), '0);
      drain();

      // Random phases: whole tiles with random content, palette writes mixed in.
      count = 0;
      while (count < 100) begin
         fmt = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 11))
                                         : 4'($urandom_range(10));
         configure(11'(fmt), 11'($urandom_range(3)), rand_size(), rand_size());
         nwords = (fmt == FMT_RGBA8) ? 8 : 4;
         for (int t = 0; t < 6 + $urandom_range(4); t++) begin
            for (int k = 0; k < nwords; k++) begin
               if ($urandom_range(9) == 0) begin
                  push_word(OP_PAL_WRITE, rand64(), 14'($urandom));
                  count++;
               end
               push_word(OP_DATA_WORD, data_for(fmt), 14'($urandom));
               count++;
            end
         end
         // A dangling partial tile, dropped by the next register write.
         if ($urandom_range(2) == 0) begin
            push_word(OP_DATA_WORD, data_for(fmt), '0);
            count++;
         end
         drain();
      end
      // Largest image at the end.
      configure(11'(FMT_I4), 11'd1, 11'd1024, 11'd1024);
      for (int k = 0; k < 16; k++) push_word(OP_DATA_WORD, rand64(), '0);
      drain();

      $display("Covered %0d input transfers and %0d checked texels across all formats,",
               words_accepted, texels_checked);
      $display("palette encodings, clipped edges and clamped image sizes.");
      if (error_count == 0 && expected_texels.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// ===== tiled_texture_block_decoder.f =====
design/ttbd_pkg.sv
design/ttbd_if.sv
design/ttbd_tile_mem.sv
design/ttbd_pal_mem.sv
design/tiled_texture_block_decoder.sv
dv/tb_top.sv
